// ===== design/usbmsx_pkg.sv =====
// Shared types and constants for the USB-MIDI SysEx reassembler.
package usbmsx_pkg;

  localparam int BufferBytesDef = 64;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_CC       = 3'd1,
    KIND_INVALID  = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_e;

  localparam logic [3:0] CIN_SYSEX      = 4'd4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'd5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'd6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'd7;
  localparam logic [3:0] CIN_CTRL       = 4'd11;
  localparam logic [3:0] CIN_SINGLE     = 4'd15;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_STOP  = 8'hF7;
  localparam logic [3:0] CC_STATUS   = 4'hB;

endpackage

// ===== design/usb_midi_sysex_reassembler.sv =====
// USB-MIDI SysEx reassembler: byte store, packet decode and message replay.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, header..third_byte | in
//  out     | out_valid_o/out_ready_i, result fields    | out
//
// An input beat is taken only when the sequencer is idle; appending writes
// the bytes one after another (single write port of the store). Replay reads
// each byte from the store, then loads it into the output register.
// Reset clears the position, the sequencer and the output valid; the store
// is not cleared. A stalled output holds the sequencer until the beat drains.
module usb_midi_sysex_reassembler #(
  parameter int BUFFER_BYTES = usbmsx_pkg::BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] header_byte_i,
  input  logic [7:0] first_byte_i,
  input  logic [7:0] second_byte_i,
  input  logic [7:0] third_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] result_kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] control_number_o,
  output logic [7:0] control_value_o,
  output logic       last_of_run_o
);
  import usbmsx_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);

  typedef enum logic [2:0] {S_IDLE, S_APPEND, S_READ, S_LOAD, S_EMIT} state_e;

  state_e        state_q;
  logic [PW-1:0] pos_q;
  logic [7:0]    first_q;
  logic [7:0]    b_q [3];
  logic [1:0]    idx_q, count_q;
  logic          replay_q;
  logic [AW-1:0] rd_idx_q;
  logic [7:0]    rdata_q;
  logic [7:0]    mem_q [BUFFER_BYTES];

  kind_e         pend_kind_q;
  logic [7:0]    pend_data_q, pend_num_q, pend_val_q;

  logic          out_valid_q, last_q;
  kind_e         kind_q;
  logic [7:0]    data_q, num_q, val_q;

  logic          in_fire, out_free, out_load, mem_we, rd_last;
  logic [3:0]    cin;
  logic [PW:0]   pos_ext, buf_ext;
  logic [7:0]    end_byte;

  logic          act_emit, act_append, act_replay, act_clear;
  logic [1:0]    act_count;
  kind_e         act_kind;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = out_free && (state_q == S_LOAD || state_q == S_EMIT);
  assign cin        = header_byte_i[3:0];
  assign pos_ext    = {1'b0, pos_q};
  assign buf_ext    = (PW + 1)'(BUFFER_BYTES);
  assign mem_we     = (state_q == S_APPEND);
  assign rd_last    = (PW'(rd_idx_q) + PW'(1)) == pos_q;

  always_comb begin
    unique case (cin[1:0])
      2'd1:    end_byte = first_byte_i;
      2'd2:    end_byte = second_byte_i;
      default: end_byte = third_byte_i;
    endcase
  end

  always_comb begin
    act_emit   = 1'b0;
    act_append = 1'b0;
    act_replay = 1'b0;
    act_clear  = 1'b0;
    act_count  = 2'd0;
    act_kind   = KIND_REJECT;
    unique case (cin)
      CIN_SINGLE: begin
        if (first_byte_i == SYSEX_STOP && pos_q > PW'(2)) begin
          if (pos_ext >= buf_ext) begin
            act_emit = 1'b1; act_kind = KIND_OVERFLOW; act_clear = 1'b1;
          end else begin
            act_append = 1'b1; act_count = 2'd1; act_replay = 1'b1;
          end
        end else if (first_byte_i[7]) begin
          act_emit = 1'b0;
        end else if (pos_q > PW'(2)) begin
          if (pos_ext >= buf_ext) begin
            act_emit = 1'b1; act_kind = KIND_OVERFLOW; act_clear = 1'b1;
          end else begin
            act_append = 1'b1; act_count = 2'd1;
          end
        end else begin
          act_emit = 1'b1; act_kind = KIND_REJECT; act_clear = 1'b1;
        end
      end
      CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
        if (pos_q < PW'(3) || first_q != SYSEX_START || end_byte != SYSEX_STOP) begin
          act_emit = 1'b1; act_kind = KIND_INVALID; act_clear = 1'b1;
        end else if (pos_ext + (PW + 1)'(cin[1:0]) > buf_ext) begin
          act_emit = 1'b1; act_kind = KIND_OVERFLOW; act_clear = 1'b1;
        end else begin
          act_append = 1'b1; act_count = cin[1:0]; act_replay = 1'b1;
        end
      end
      CIN_SYSEX: begin
        if (pos_ext + (PW + 1)'(3) > buf_ext) begin
          act_emit = 1'b1; act_kind = KIND_OVERFLOW; act_clear = 1'b1;
        end else begin
          act_append = 1'b1; act_count = 2'd3;
        end
      end
      CIN_CTRL: begin
        act_emit = 1'b1;
        if (first_byte_i[7:4] != CC_STATUS) begin
          act_kind = KIND_REJECT; act_clear = 1'b1;
        end else begin
          act_kind = KIND_CC;
        end
      end
      default: act_emit = 1'b0;
    endcase
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pos_q[AW-1:0]] <= b_q[idx_q];
    end
    if (state_q == S_READ) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      count_q     <= '0;
      replay_q    <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            b_q[0]   <= first_byte_i;
            b_q[1]   <= second_byte_i;
            b_q[2]   <= third_byte_i;
            idx_q    <= '0;
            count_q  <= act_count;
            replay_q <= act_replay;
            if (act_clear) begin
              pos_q <= '0;
            end
            if (act_emit) begin
              pend_kind_q <= act_kind;
              pend_data_q <= (act_kind == KIND_CC) ? first_byte_i : 8'd0;
              pend_num_q  <= (act_kind == KIND_CC) ? second_byte_i : 8'd0;
              pend_val_q  <= (act_kind == KIND_CC) ? third_byte_i : 8'd0;
              state_q     <= S_EMIT;
            end else if (act_append) begin
              state_q <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (pos_q == '0) begin
            first_q <= b_q[idx_q];
          end
          pos_q <= pos_q + PW'(1);
          idx_q <= idx_q + 2'd1;
          if (idx_q == count_q - 2'd1) begin
            rd_idx_q <= '0;
            state_q  <= replay_q ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= KIND_BYTE;
            data_q      <= rdata_q;
            num_q       <= 8'd0;
            val_q       <= 8'd0;
            last_q      <= rd_last;
            if (rd_last) begin
              pos_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q + AW'(1);
              state_q  <= S_READ;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= pend_kind_q;
            data_q      <= pend_data_q;
            num_q       <= pend_num_q;
            val_q       <= pend_val_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign data_byte_o      = data_q;
  assign control_number_o = num_q;
  assign control_value_o  = val_q;
  assign last_of_run_o    = last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(BUFFER_BYTES))
    else $error("write position beyond store");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> pos_q < PW'(BUFFER_BYTES))
    else $error("store write out of range");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_BYTE |-> last_of_run_o)
    else $error("single result without last flag");

  a_replay_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD && out_free && rd_last |=> pos_q == '0)
    else $error("position not cleared after replay");

endmodule
